// ----- src/wmmd_pkg.sv -----
// Shared types and constants for the window min/max index decimator.
package wmmd_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int INDEX_BITS_DEF  = 32;
    localparam int SPP_BITS        = 16;
    localparam int OUT_INDEX_BITS  = 32;

    localparam logic [SPP_BITS-1:0] SPP_RESET = SPP_BITS'(256);

    typedef struct packed {
        logic valid;
        logic last;
    } wmmd_ctl_t;

endpackage

// ----- src/wmmd_input_stage.sv -----
// Input register: holds one accepted sample word until the tracker consumes it.
module wmmd_input_stage #(
    parameter int SAMPLE_BITS = wmmd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    input  logic                          s_last,
    input  logic                          consume,
    output wmmd_pkg::wmmd_ctl_t           ctl,
    output logic signed [SAMPLE_BITS-1:0] sample
);
    import wmmd_pkg::*;

    logic                          valid_reg;
    logic                          last_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;

    assign s_ready = !valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (consume) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sample_reg <= s_sample;
            last_reg   <= s_last;
        end
    end

    assign ctl.valid = valid_reg;
    assign ctl.last  = last_reg;
    assign sample    = sample_reg;

endmodule

// ----- src/wmmd_tracker.sv -----
// Window tracker: min/max compare, window/index counters and result register.
module wmmd_tracker #(
    parameter int SAMPLE_BITS = wmmd_pkg::SAMPLE_BITS_DEF,
    parameter int INDEX_BITS  = wmmd_pkg::INDEX_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  wmmd_pkg::wmmd_ctl_t                     ctl,
    input  logic signed [SAMPLE_BITS-1:0]           sample,
    input  logic [wmmd_pkg::SPP_BITS-1:0]           samples_per_pixel,
    output logic                                    consume,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [wmmd_pkg::OUT_INDEX_BITS-1:0]     m_first_index,
    output logic [wmmd_pkg::OUT_INDEX_BITS-1:0]     m_second_index,
    output logic                                    m_final_window
);
    import wmmd_pkg::*;

    localparam int WIDE_BITS = (INDEX_BITS > OUT_INDEX_BITS) ? INDEX_BITS : OUT_INDEX_BITS;

    logic [INDEX_BITS-1:0]         count_reg,   count_next;
    logic [SPP_BITS-1:0]           wpos_reg,    wpos_next;
    logic signed [SAMPLE_BITS-1:0] min_val_reg, min_val_next;
    logic signed [SAMPLE_BITS-1:0] max_val_reg, max_val_next;
    logic [INDEX_BITS-1:0]         min_pos_reg, min_pos_next;
    logic [INDEX_BITS-1:0]         max_pos_reg, max_pos_next;

    logic                          m_valid_reg;
    logic [OUT_INDEX_BITS-1:0]     first_reg, second_reg;
    logic                          final_reg;

    logic [SPP_BITS-1:0]           len;
    logic [SPP_BITS-1:0]           wpos_inc;
    logic                          close;
    logic [INDEX_BITS-1:0]         lo, hi;
    logic [WIDE_BITS-1:0]          lo_wide, hi_wide;

    assign consume = !m_valid_reg || m_ready;

    always_comb begin
        len      = (samples_per_pixel == '0) ? SPP_BITS'(1) : samples_per_pixel;
        wpos_inc = wpos_reg + SPP_BITS'(1);
        close    = ctl.last || (wpos_inc == '0) || (wpos_inc >= len);

        if (wpos_reg == '0) begin
            min_val_next = sample;
            max_val_next = sample;
            min_pos_next = count_reg;
            max_pos_next = count_reg;
        end else begin
            min_val_next = min_val_reg;
            max_val_next = max_val_reg;
            min_pos_next = min_pos_reg;
            max_pos_next = max_pos_reg;
            if (sample < min_val_reg) begin
                min_val_next = sample;
                min_pos_next = count_reg;
            end
            if (sample > max_val_reg) begin
                max_val_next = sample;
                max_pos_next = count_reg;
            end
        end

        wpos_next  = close ? '0 : wpos_inc;
        count_next = (close && ctl.last) ? '0 : count_reg + INDEX_BITS'(1);

        if (min_pos_next <= max_pos_next) begin
            lo = min_pos_next;
            hi = max_pos_next;
        end else begin
            lo = max_pos_next;
            hi = min_pos_next;
        end
        lo_wide = WIDE_BITS'(lo);
        hi_wide = WIDE_BITS'(hi);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            wpos_reg    <= '0;
            min_val_reg <= '0;
            max_val_reg <= '0;
            min_pos_reg <= '0;
            max_pos_reg <= '0;
        end else if (ctl.valid && consume) begin
            count_reg   <= count_next;
            wpos_reg    <= wpos_next;
            min_val_reg <= min_val_next;
            max_val_reg <= max_val_next;
            min_pos_reg <= min_pos_next;
            max_pos_reg <= max_pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (consume) begin
            m_valid_reg <= ctl.valid && close;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && ctl.valid && close) begin
            first_reg  <= lo_wide[OUT_INDEX_BITS-1:0];
            second_reg <= hi_wide[OUT_INDEX_BITS-1:0];
            final_reg  <= ctl.last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_first_index  = first_reg;
    assign m_second_index = second_reg;
    assign m_final_window = final_reg;

endmodule

// ----- src/window_min_max_index_decimator_unit.sv -----
// A window's closing sample is held in the input register, its word then in the result register.
// Throughput: one sample word per cycle unless a result waits on m_ready; a window closes
// as its last sample is tracked. The compare against the held min/max sets the single-cycle path.
// Reset (aresetn low, synchronous): counters and extremes clear, no word pending,
// and the window length returns to 256 samples.
module window_min_max_index_decimator_unit #(
    parameter int SAMPLE_BITS = wmmd_pkg::SAMPLE_BITS_DEF,
    parameter int INDEX_BITS  = wmmd_pkg::INDEX_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wmmd_pkg::SPP_BITS-1:0]       cfg_samples_per_pixel,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [SAMPLE_BITS-1:0]       s_sample,
    input  logic                                s_last,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [wmmd_pkg::OUT_INDEX_BITS-1:0] m_first_index,
    output logic [wmmd_pkg::OUT_INDEX_BITS-1:0] m_second_index,
    output logic                                m_final_window
);
    import wmmd_pkg::*;

    logic [SPP_BITS-1:0]           spp_reg;
    wmmd_ctl_t                     ctl;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          consume;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spp_reg <= SPP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            spp_reg <= cfg_samples_per_pixel;
        end
    end

    wmmd_input_stage #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_input (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_sample (s_sample),
        .s_last   (s_last),
        .consume  (consume),
        .ctl      (ctl),
        .sample   (sample)
    );

    wmmd_tracker #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_tracker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .ctl               (ctl),
        .sample            (sample),
        .samples_per_pixel (spp_reg),
        .consume           (consume),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_first_index     (m_first_index),
        .m_second_index    (m_second_index),
        .m_final_window    (m_final_window)
    );

    // input side never stalls while no result word is pending
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low with empty result register");

    // a new result word follows an accepted sample through the input and result registers
    a_result_has_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result word without matching accepted sample");

    // a held sample is consumed while no result word is pending
    a_consume_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.valid && !m_valid) |=> (m_valid || !ctl.valid || $past(s_valid && s_ready)))
        else $error("held sample not consumed with result register empty");

endmodule

// ----- sim/window_min_max_index_decimator_unit_tb.sv -----
// Self-checking testbench for window_min_max_index_decimator_unit: random and directed words.
module window_min_max_index_decimator_unit_tb;

    import wmmd_pkg::*;

    typedef struct packed {
        logic signed [SAMPLE_BITS_DEF-1:0] value;
        logic                              ends_set;
    } sample_word_t;

    typedef struct packed {
        logic [OUT_INDEX_BITS-1:0] first_index;
        logic [OUT_INDEX_BITS-1:0] second_index;
        logic                      final_window;
    } index_pair_t;

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [SPP_BITS-1:0]                cfg_samples_per_pixel = '0;
    logic                               s_valid = 1'b0;
    logic                               s_ready;
    logic signed [SAMPLE_BITS_DEF-1:0]  s_sample = '0;
    logic                               s_last = 1'b0;
    logic                               m_valid;
    logic                               m_ready = 1'b0;
    logic [OUT_INDEX_BITS-1:0]          m_first_index;
    logic [OUT_INDEX_BITS-1:0]          m_second_index;
    logic                               m_final_window;

    sample_word_t sample_backlog[$];
    index_pair_t  expected_pairs[$];
    int unsigned  error_count = 0;
    int unsigned  s_idle_pct = 0;
    int unsigned  m_stall_pct = 0;

    // window tracker state
    logic [SPP_BITS-1:0]               win_len = SPP_RESET;
    logic [SPP_BITS-1:0]               win_fill = '0;
    logic [INDEX_BITS_DEF-1:0]         next_index = '0;
    logic signed [SAMPLE_BITS_DEF-1:0] ext_min = '0;
    logic signed [SAMPLE_BITS_DEF-1:0] ext_max = '0;
    logic [INDEX_BITS_DEF-1:0]         ext_min_at = '0;
    logic [INDEX_BITS_DEF-1:0]         ext_max_at = '0;

    window_min_max_index_decimator_unit dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_samples_per_pixel (cfg_samples_per_pixel),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_sample              (s_sample),
        .s_last                (s_last),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_first_index         (m_first_index),
        .m_second_index        (m_second_index),
        .m_final_window        (m_final_window)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 40) begin
            $display("%0t mismatch: %s", $realtime, what);
        end
    endtask

    task automatic track_sample(input logic signed [SAMPLE_BITS_DEF-1:0] value,
                                input logic ends_set);
        logic [SPP_BITS-1:0]       len;
        logic [INDEX_BITS_DEF-1:0] idx;
        index_pair_t               pair;
        len = (win_len == '0) ? SPP_BITS'(1) : win_len;
        idx = next_index;
        if (win_fill == '0) begin
            ext_min = value;
            ext_max = value;
            ext_min_at = idx;
            ext_max_at = idx;
        end else begin
            if (value < ext_min) begin
                ext_min = value;
                ext_min_at = idx;
            end
            if (value > ext_max) begin
                ext_max = value;
                ext_max_at = idx;
            end
        end
        win_fill = win_fill + SPP_BITS'(1);
        next_index = next_index + INDEX_BITS_DEF'(1);
        if (ends_set || win_fill == '0 || win_fill >= len) begin
            if (ext_min_at <= ext_max_at) begin
                pair.first_index = OUT_INDEX_BITS'(ext_min_at);
                pair.second_index = OUT_INDEX_BITS'(ext_max_at);
            end else begin
                pair.first_index = OUT_INDEX_BITS'(ext_max_at);
                pair.second_index = OUT_INDEX_BITS'(ext_min_at);
            end
            pair.final_window = ends_set;
            expected_pairs.push_back(pair);
            win_fill = '0;
            if (ends_set) begin
                next_index = '0;
            end
        end
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                track_sample(s_sample, s_last);
            end
            if (!s_valid || s_ready) begin
                if (sample_backlog.size() > 0 && $urandom_range(99) >= s_idle_pct) begin
                    sample_word_t w;
                    w = sample_backlog.pop_front();
                    s_valid <= 1'b1;
                    s_sample <= w.value;
                    s_last <= w.ends_set;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_pairs.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %0d/%0d/%0b",
                        m_first_index, m_second_index, m_final_window));
                end else begin
                    index_pair_t want;
                    want = expected_pairs.pop_front();
                    if (m_first_index !== want.first_index) begin
                        report_mismatch($sformatf("first_index %0d, want %0d",
                            m_first_index, want.first_index));
                    end
                    if (m_second_index !== want.second_index) begin
                        report_mismatch($sformatf("second_index %0d, want %0d",
                            m_second_index, want.second_index));
                    end
                    if (m_final_window !== want.final_window) begin
                        report_mismatch($sformatf("final_window %0b, want %0b",
                            m_final_window, want.final_window));
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= m_stall_pct);
        end
    end

    task automatic push_word(input int value, input bit ends_set);
        sample_word_t w;
        w.value = SAMPLE_BITS_DEF'(value);
        w.ends_set = ends_set;
        sample_backlog.push_back(w);
    endtask

    task automatic drain();
        do begin
            @(posedge aclk);
        end while (sample_backlog.size() > 0 || s_valid || expected_pairs.size() > 0);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_len(input logic [SPP_BITS-1:0] len);
        drain();
        cfg_valid <= 1'b1;
        cfg_samples_per_pixel <= len;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        win_len = len;
        cfg_valid <= 1'b0;
    endtask

    function automatic int random_sample();
        case ($urandom_range(9))
            0: return -32768;
            1: return 32767;
            2, 3, 4: return $urandom_range(4) - 2;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    task automatic set_idling(input int mode);
        case (mode)
            0: begin s_idle_pct = 0;  m_stall_pct = 0;  end
            1: begin s_idle_pct = 60; m_stall_pct = 0;  end
            2: begin s_idle_pct = 0;  m_stall_pct = 60; end
            default: begin s_idle_pct = 22; m_stall_pct = 22; end
        endcase
    endtask

    initial begin
        logic [SPP_BITS-1:0] phase_len[8];
        int unsigned phase_items;
        int unsigned span;
        int unsigned n;
        bit closes;
        phase_len = '{16'd3, 16'd1, 16'd0, 16'd65535, 16'd5, 16'd2, 16'd256, 16'd17};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset length 256: extremes, ties, min before max
        push_word(100, 0);
        push_word(100, 0);
        push_word(-32768, 0);
        push_word(32767, 0);
        push_word(-32768, 0);
        push_word(32767, 0);
        push_word(0, 0);
        push_word(-1, 1);
        // single-sample data set
        push_word(32767, 1);
        // zero length acts as one
        write_len(16'd0);
        push_word(-5, 0);
        push_word(7, 0);
        push_word(7, 1);
        // max before min, all-equal window, partial final window
        write_len(16'd3);
        push_word(1, 0);
        push_word(-1, 0);
        push_word(0, 0);
        push_word(2, 0);
        push_word(2, 0);
        push_word(2, 0);
        push_word(5, 1);
        // length shrinks mid-window
        write_len(16'd5);
        push_word(4, 0);
        push_word(-4, 0);
        write_len(16'd1);
        push_word(9, 0);
        push_word(-9, 1);

        for (int p = 0; p < 8; p++) begin
            write_len(phase_len[p]);
            set_idling(p % 4);
            phase_items = 0;
            while (phase_items < 165) begin
                span = (phase_len[p] > 12 || phase_len[p] == 0) ?
                       ((phase_len[p] == 0) ? 4 : 48) : phase_len[p] * 4;
                n = $urandom_range(span, 1);
                closes = ($urandom_range(7) != 0);
                for (int i = 0; i < n; i++) begin
                    push_word(random_sample(), closes && (i == n - 1));
                end
                phase_items += n;
                if ($urandom_range(9) == 0) begin
                    drain();
                end
            end
        end

        drain();
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
src/wmmd_pkg.sv
src/wmmd_input_stage.sv
src/wmmd_tracker.sv
src/window_min_max_index_decimator_unit.sv
sim/window_min_max_index_decimator_unit_tb.sv
